// ===== sv/impq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue package
// Shared types and constants for the indexed binary min-heap.
// ----------------------------------------------------------------------------
package impq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned PosW     = $clog2(Capacity);
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned IdW      = 8;
  localparam int unsigned KeyW     = 32;
  localparam int unsigned IdSpace  = 1 << IdW;

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_EXTRACT = 2'd1,
    KIND_DEC     = 2'd2,
    KIND_NOP     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_FULL_DUP  = 3'd2,
    ST_NOT_LESS  = 3'd3,
    ST_ABSENT    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  item_id;
    logic [31:0] new_key;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_id;
    logic [31:0] out_key;
    logic [8:0]  entries_held;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC_RD,     // read position of id
    S_DEC_KEY,    // read the slot at that position
    S_DEC_CHK,
    S_EXT_RD,     // read the last slot
    S_UP_RD,      // read parent
    S_UP_CMP,
    S_DN_RDL,     // read left child
    S_DN_RDR,     // read right child
    S_DN_CMP,
    S_DONE
  } fsm_e;

endpackage

// ===== sv/indexed_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue
// Binary min-heap of (key, id) entries in a slot memory with a position map.
// A request refused at once goes straight to the result beat; otherwise insert
// and decrease-key sift up, each level through S_UP_RD and S_UP_CMP, and
// extract sifts down, each level through S_DN_RDL, S_DN_RDR and S_DN_CMP.
// One request at a time: the next start beat is taken in the cycle after done_o.
// The receiver cannot stall. Reset clears the state, count and presence bits only.
// ----------------------------------------------------------------------------
module indexed_min_priority_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  impq_pkg::req_t req_i,
  output logic           done_o,
  output impq_pkg::rsp_t rsp_o
);
  import impq_pkg::*;

  // Slot memory holds {key, id}; position map is separate.
  logic [KeyW+IdW-1:0] slot_mem [Capacity];
  logic [PosW-1:0]     pos_mem  [IdSpace];
  logic [IdSpace-1:0]  present_q, present_d;

  fsm_e state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [IdW-1:0]    id_q, id_d;      // moving entry
  logic [KeyW-1:0]   key_q, key_d;
  logic [PosW-1:0]   pos_q, pos_d;    // hole position
  logic [KeyW-1:0]   bkey_q, bkey_d;  // best child so far in sift-down
  logic [IdW-1:0]    bid_q, bid_d;
  logic [PosW:0]     bpos_q, bpos_d;
  logic              bsel_q, bsel_d;
  rsp_t              rsp_q, rsp_d;

  logic              s_rd;
  logic [PosW-1:0]   s_raddr;
  logic [KeyW+IdW-1:0] s_rdata;
  logic              s_we;
  logic [PosW-1:0]   s_waddr;
  logic [KeyW+IdW-1:0] s_wdata;
  logic              p_we;
  logic [IdW-1:0]    p_waddr, p_raddr;
  logic [PosW-1:0]   p_wdata, p_rdata;

  always_ff @(posedge clk_i) begin
    if (s_we) slot_mem[s_waddr] <= s_wdata;
    if (s_rd) s_rdata <= slot_mem[s_raddr];
    if (p_we) pos_mem[p_waddr] <= p_wdata;
    p_rdata <= pos_mem[p_raddr];
  end

  logic [KeyW-1:0] rkey;
  logic [IdW-1:0]  rid;
  assign rkey = s_rdata[KeyW+IdW-1:IdW];
  assign rid  = s_rdata[IdW-1:0];

  logic [PosW:0] lpos, rpos;
  assign lpos = {pos_q, 1'b1};
  assign rpos = {pos_q, 1'b1} + 1'b1;

  function automatic rsp_t mk(status_e s, logic [IdW-1:0] i, logic [KeyW-1:0] k,
                              logic [CountW-1:0] c);
    rsp_t r;
    r.status = s;
    r.out_id = i;
    r.out_key = k;
    r.entries_held = 9'(c);
    return r;
  endfunction

  always_comb begin
    state_d = state_q; count_d = count_q; id_d = id_q;
    key_d = key_q; pos_d = pos_q; bkey_d = bkey_q; bid_d = bid_q;
    bpos_d = bpos_q; bsel_d = bsel_q; rsp_d = rsp_q; present_d = present_q;
    s_rd = 1'b0; s_raddr = '0; s_we = 1'b0; s_waddr = pos_q;
    s_wdata = {key_q, id_q}; p_we = 1'b0; p_waddr = id_q; p_wdata = pos_q;
    p_raddr = req_i.item_id;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          id_d = req_i.item_id; key_d = req_i.new_key;
          case (kind_e'(req_i.kind))
            KIND_INSERT: begin
              if (count_q >= CountW'(Capacity) || present_q[req_i.item_id]) begin
                rsp_d = mk(ST_FULL_DUP, '0, '0, count_q);
                state_d = S_DONE;
              end else begin
                present_d[req_i.item_id] = 1'b1;
                pos_d = PosW'(count_q);
                count_d = count_q + 1'b1;
                state_d = S_UP_RD;
              end
            end
            KIND_EXTRACT: begin
              if (count_q == '0) begin
                rsp_d = mk(ST_EMPTY, '0, '0, count_q);
                state_d = S_DONE;
              end else begin
                s_rd = 1'b1; s_raddr = '0;
                state_d = S_EXT_RD;
              end
            end
            KIND_DEC: begin
              if (!present_q[req_i.item_id]) begin
                rsp_d = mk(ST_ABSENT, '0, '0, count_q);
                state_d = S_DONE;
              end else begin
                state_d = S_DEC_RD;
              end
            end
            default: begin
              rsp_d = mk(ST_OK, '0, '0, count_q);
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_DEC_RD: begin
        pos_d = p_rdata;
        s_rd = 1'b1; s_raddr = p_rdata;
        state_d = S_DEC_KEY;
      end
      S_DEC_KEY: state_d = S_DEC_CHK;
      S_DEC_CHK: begin
        if ({1'b0, pos_q} >= count_q) begin
          rsp_d = mk(ST_ABSENT, '0, '0, count_q);
          state_d = S_DONE;
        end else if (key_q >= rkey) begin
          rsp_d = mk(ST_NOT_LESS, '0, '0, count_q);
          state_d = S_DONE;
        end else begin
          state_d = S_UP_RD;
        end
      end
      S_EXT_RD: begin
        // Root data is valid now; read the last slot next.
        present_d[rid] = 1'b0;
        count_d = count_q - 1'b1;
        rsp_d = mk(ST_OK, rid, rkey, count_q - 1'b1);
        if (count_q == CountW'(1)) begin
          state_d = S_DONE;
        end else begin
          s_rd = 1'b1; s_raddr = PosW'(count_q - 1'b1);
          pos_d = '0;
          bsel_d = 1'b1;
          state_d = S_DN_RDL;
        end
      end
      S_UP_RD: begin
        if (pos_q == '0) begin
          s_we = 1'b1; p_we = 1'b1;
          rsp_d = mk(ST_OK, '0, '0, count_q);
          state_d = S_DONE;
        end else begin
          s_rd = 1'b1; s_raddr = (pos_q - 1'b1) >> 1;
          state_d = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (rkey < key_q) begin
          s_we = 1'b1; p_we = 1'b1;
          rsp_d = mk(ST_OK, '0, '0, count_q);
          state_d = S_DONE;
        end else begin
          // Parent moves down into the hole.
          s_we = 1'b1; s_wdata = s_rdata;
          p_we = 1'b1; p_waddr = rid;
          pos_d = (pos_q - 1'b1) >> 1;
          state_d = S_UP_RD;
        end
      end
      S_DN_RDL: begin
        // bsel_q marks the first pass, when the last slot's data arrives.
        if (bsel_q) begin
          key_d = rkey; id_d = rid; bsel_d = 1'b0;
        end
        if (lpos < (PosW+1)'(count_q)) begin
          s_rd = 1'b1; s_raddr = lpos[PosW-1:0];
          state_d = S_DN_RDR;
        end else begin
          s_we = 1'b1; p_we = 1'b1;
          if (bsel_q) begin
            s_wdata = s_rdata; p_waddr = rid;
          end
          state_d = S_DONE;
        end
      end
      S_DN_RDR: begin
        bkey_d = key_q; bid_d = id_q; bpos_d = {1'b0, pos_q};
        if (rkey <= key_q) begin
          bkey_d = rkey; bid_d = rid; bpos_d = lpos;
        end
        if (rpos < (PosW+1)'(count_q)) begin
          s_rd = 1'b1; s_raddr = rpos[PosW-1:0];
        end
        state_d = S_DN_CMP;
        bsel_d = rpos < (PosW+1)'(count_q);
      end
      S_DN_CMP: begin
        logic [KeyW-1:0] k;
        logic [IdW-1:0]  i;
        logic [PosW:0]   p;
        k = bkey_q; i = bid_q; p = bpos_q;
        if (bsel_q && rkey <= bkey_q) begin
          k = rkey; i = rid; p = rpos;
        end
        bsel_d = 1'b0;
        if (p == {1'b0, pos_q}) begin
          s_we = 1'b1; p_we = 1'b1;
          state_d = S_DONE;
        end else begin
          s_we = 1'b1; s_wdata = {k, i};
          p_we = 1'b1; p_waddr = i;
          pos_d = p[PosW-1:0];
          state_d = S_DN_RDL;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      present_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d; key_q <= key_d; pos_q <= pos_d;
    bkey_q <= bkey_d; bid_q <= bid_d; bpos_q <= bpos_d; bsel_q <= bsel_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o  = rsp_q;

endmodule

// ===== sv/impq_checker.sv =====
// ----------------------------------------------------------------------------
// Indexed min priority queue checker
// Port-level properties of the request and result beats.
// ----------------------------------------------------------------------------
module impq_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input impq_pkg::rsp_t rsp_o
);
  import impq_pkg::*;

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("start beat not taken");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held");

  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.status <= ST_ABSENT && rsp_o.entries_held <= 9'(Capacity))
    else $error("result out of range");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status != ST_OK |-> rsp_o.out_id == '0 && rsp_o.out_key == '0)
    else $error("failed request reports an entry");

endmodule

bind indexed_min_priority_queue impq_checker u_impq_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
  .done_o(done_o), .rsp_o(rsp_o)
);
